>>> hdl/ums_pkg.sv
// Package for the unordered multiset store: sizes, command codes and the state type.
// Used by the top level of the store; depends on nothing.
`timescale 1ns / 1ps
package ums_pkg;
  localparam int CAPACITY    = 16;
  localparam int ITEM_WIDTH  = 32;
  localparam int SLOT_WIDTH  = $clog2(CAPACITY);
  localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
  localparam int CMD_WIDTH   = 3;

  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_CONTAINS = 3'd2,
    CMD_TAKE     = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_DONE
  } state_t;
endpackage

>>> hdl/ums_cell.sv
// One cell of the storage chain: holds one item word and shifts it to its neighbour.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module ums_cell #(
  parameter int ITEM_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic [ITEM_WIDTH-1:0] din,
  output logic [ITEM_WIDTH-1:0] dout
);
  logic [ITEM_WIDTH-1:0] word;

  always_ff @(posedge clk) begin
    if (load) begin
      word <= din;
    end
  end

  assign dout = word;
endmodule

>>> hdl/unordered_multiset_store_top.sv
// Top level of the unordered multiset store: control sequencer and the cell ring.
// Depends on ums_pkg and ums_cell.
// The store holds up to ums_pkg::CAPACITY item words in a ring of cells. At rest cell i
// holds entry i; a scan rotates the ring by one place per cycle, so after a full scan
// every entry is back in its own cell. The head cell is the one compared or read.
// A request enters on s_tvalid/s_tready; each request gives exactly one result on
// m_tvalid/m_tready. Append, clear, take on an empty store and unused codes offer their
// result in the cycle after the request is accepted. Remove and contains scan the whole
// ring in ST_SCAN and offer their result in ST_DONE. Take first reduces its cursor by
// repeated subtraction of the fill in ST_MOD, then scans like remove. One request is
// worked on at a time; s_tready is low until its result is taken and rises in the
// following cycle. A stalled receiver holds the result and the block waits.
// Reset empties the store and clears the take cursor; the cells are not cleared.
`timescale 1ns / 1ps
module unordered_multiset_store_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // cmd [2:0], item [34:3], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // ok, item_out [32:1], slot [36:33], count [41:37], zeros
);
  localparam int CAP = ums_pkg::CAPACITY;
  localparam int IW  = ums_pkg::ITEM_WIDTH;
  localparam int AW  = ums_pkg::SLOT_WIDTH;
  localparam int CW  = ums_pkg::COUNT_WIDTH;

  ums_pkg::state_t state, state_next;
  logic [ums_pkg::CMD_WIDTH-1:0] cmd;
  logic [IW-1:0] key;
  logic [IW-1:0] last_word;
  logic [IW-1:0] sec_word;
  logic [CW-1:0] fill, cursor;
  logic [AW-1:0] pos;
  logic [AW-1:0] hit_idx;
  logic found;
  logic ok_r;
  logic [IW-1:0] out_item;
  logic [AW-1:0] out_slot;

  logic [IW-1:0] cdout [CAP];
  logic [IW-1:0] cdin  [CAP];
  logic cload [CAP];
  logic rotate;
  logic app_wr;
  logic in_fill;
  logic hit;
  logic swap;
  logic gone;
  logic [AW-1:0] idx_now;
  logic [IW-1:0] head;
  logic [IW-1:0] s_item;

  assign s_item = s_tdata[IW+2:3];
  assign head   = cdout[0];

  assign app_wr  = (state == ums_pkg::ST_IDLE) && s_tvalid
                   && (s_tdata[2:0] == ums_pkg::CMD_APPEND) && (fill < CW'(CAP));
  assign in_fill = CW'(pos) < fill;
  assign hit     = in_fill && !found && ((cmd == ums_pkg::CMD_TAKE) ? (CW'(pos) == cursor)
                                                                  : (head == key));
  // The matching entry is replaced by the last entry as it moves to the tail.
  assign swap    = hit && (cmd != ums_pkg::CMD_CONTAINS);
  assign gone    = (found || hit) && (cmd != ums_pkg::CMD_CONTAINS);
  assign idx_now = hit ? pos : hit_idx;

  genvar g;
  generate
    for (g = 0; g < CAP; g++) begin : g_cell
      logic wr_here;
      assign wr_here  = app_wr && (fill == CW'(g));
      assign cload[g] = rotate | wr_here;
      if (g == CAP - 1) begin : g_tail
        assign cdin[g] = wr_here ? s_item : (swap ? last_word : cdout[0]);
      end else begin : g_body
        assign cdin[g] = wr_here ? s_item : cdout[g + 1];
      end
      ums_cell #(.ITEM_WIDTH(IW)) u_cell (
        .clk  (clk),
        .load (cload[g]),
        .din  (cdin[g]),
        .dout (cdout[g])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    rotate = 1'b0;
    unique case (state)
      ums_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tdata[2:0])
            ums_pkg::CMD_REMOVE, ums_pkg::CMD_CONTAINS: state_next = ums_pkg::ST_SCAN;
            ums_pkg::CMD_TAKE: state_next = (fill != '0) ? ums_pkg::ST_MOD
                                                           : ums_pkg::ST_DONE;
            default: state_next = ums_pkg::ST_DONE;
          endcase
        end
      end
      ums_pkg::ST_MOD: begin
        if (cursor < fill) begin
          state_next = ums_pkg::ST_SCAN;
        end
      end
      ums_pkg::ST_SCAN: begin
        rotate = 1'b1;
        if (pos == AW'(CAP - 1)) begin
          state_next = ums_pkg::ST_DONE;
        end
      end
      ums_pkg::ST_DONE: begin
        if (m_tready) begin
          state_next = ums_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ums_pkg::ST_IDLE;
      fill <= '0;
      cursor <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ums_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            cmd <= s_tdata[2:0];
            key <= s_item;
            pos <= '0;
            hit_idx <= '0;
            found <= 1'b0;
            ok_r <= 1'b0;
            out_item <= '0;
            out_slot <= '0;
            unique case (s_tdata[2:0])
              ums_pkg::CMD_APPEND: begin
                if (fill < CW'(CAP)) begin
                  ok_r <= 1'b1;
                  out_slot <= fill[AW-1:0];
                  fill <= fill + 1'b1;
                  last_word <= s_item;
                end
              end
              ums_pkg::CMD_CLEAR: begin
                fill <= '0;
                cursor <= '0;
                ok_r <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ums_pkg::ST_MOD: begin
          if (cursor >= fill) begin
            cursor <= cursor - fill;
          end
        end
        ums_pkg::ST_SCAN: begin
          pos <= pos + 1'b1;
          if (hit) begin
            found <= 1'b1;
            ok_r <= 1'b1;
            if (cmd != ums_pkg::CMD_CONTAINS) begin
              hit_idx <= pos;
              out_slot <= pos;
            end
            if (cmd == ums_pkg::CMD_TAKE) begin
              out_item <= head;
              cursor <= cursor + 1'b1;
            end
          end
          if ((CW'(pos) + CW'(2)) == fill) begin
            sec_word <= head;
          end
          if (pos == AW'(CAP - 1) && gone) begin
            fill <= fill - 1'b1;
            if ((CW'(idx_now) + CW'(2)) != fill) begin
              last_word <= sec_word;
            end
          end
        end
        ums_pkg::ST_DONE: ;
      endcase
    end
  end

  assign s_tready = (state == ums_pkg::ST_IDLE);
  assign m_tvalid = (state == ums_pkg::ST_DONE);
  assign m_tdata = {6'd0, fill, out_slot, out_item, ok_r};
endmodule
